[src/psrb_pkg.sv]
package psrb_pkg;

   // Defaults for the top level parameters.
   localparam int SLOTS_DEFAULT      = 8;
   localparam int SLOT_BYTES_DEFAULT = 64;

   // Field widths fixed by the interface.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int KIND_W = 2;

   // Length limit after reset.
   localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd64;

   // Request command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Response kinds.
   localparam logic [KIND_W-1:0] KIND_WRITE_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ_DATA    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ_EMPTY   = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write;       // accept one write byte
      logic read_start;  // accept a read request, look up the length
      logic emit_empty;  // place an empty response in the output register
      logic fetch;       // read the next packet byte from the store
      logic load;        // move the fetched byte into the output register
      logic finish;      // last byte delivered: free the slot, advance the read pointer
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;    // output register can take a response this cycle
      logic rd_hit;      // slot under the read pointer holds a ready packet
      logic more;        // bytes of the packet remain to be fetched
      logic pending;     // a fetched byte waits for the output register
   } ctrl_status_type;

endpackage

[src/psrb_ctrl.sv]
module psrb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_cmd,
   output logic                      req_stall,
   input  psrb_pkg::ctrl_status_type status,
   output psrb_pkg::ctrl_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_STREAM = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            // A request may leave a response behind, so room is required.
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               if (req_cmd == psrb_pkg::CMD_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.read_start = 1'b1;
                  state_in       = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!status.rd_hit) begin
               if (status.out_free) begin
                  cmd.emit_empty = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               state_in = ST_STREAM;
            end
         end
         ST_STREAM: begin
            cmd.load   = status.pending && status.out_free;
            cmd.fetch  = status.more && (!status.pending || cmd.load);
            cmd.finish = cmd.load && !status.more;
            if (cmd.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/psrb_datapath.sv]
module psrb_datapath #(
   parameter int SLOTS      = psrb_pkg::SLOTS_DEFAULT,
   parameter int SLOT_BYTES = psrb_pkg::SLOT_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [psrb_pkg::LEN_W-1:0]        csr_wr_data,
   input  logic [psrb_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              req_last_byte,
   input  psrb_pkg::ctrl_cmd_type            cmd,
   output psrb_pkg::ctrl_status_type         status,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [psrb_pkg::KIND_W-1:0]       rsp_result_kind,
   output logic [psrb_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                              rsp_out_last,
   output logic                              rsp_write_ok,
   output logic [psrb_pkg::LEN_W-1:0]        rsp_packet_length
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int ADDR_W = $clog2(SLOTS * SLOT_BYTES);
   localparam int LEN_W  = psrb_pkg::LEN_W;
   localparam int BYTE_W = psrb_pkg::BYTE_W;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      if (s == SLOT_W'(SLOTS - 1)) begin
         next_slot = '0;
      end else begin
         next_slot = s + 1'b1;
      end
   endfunction

   // Memories.
   logic [BYTE_W-1:0] store_mem [SLOTS*SLOT_BYTES];
   logic [LEN_W-1:0]  len_mem   [SLOTS];

   // Control state.
   logic [LEN_W-1:0]  limit_ff;
   logic [SLOTS-1:0]  ready_ff, ready_in;
   logic [SLOT_W-1:0] rp_ff, rp_in;
   logic [SLOT_W-1:0] wp_ff, wp_in;
   logic [SLOT_W-1:0] cws_ff, cws_in;
   logic [LEN_W-1:0]  bw_ff, bw_in;
   logic              open_ff, open_in;
   logic              too_long_ff, too_long_in;
   logic [LEN_W-1:0]  fetch_idx_ff, fetch_idx_in;
   logic              pending_ff, pending_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [LEN_W-1:0]  rd_len_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [psrb_pkg::KIND_W-1:0] kind_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;
   logic              ok_ff;
   logic [LEN_W-1:0]  len_ff;

   // Write path.
   logic [LEN_W-1:0]  limit;
   logic              start;
   logic              flush;
   logic [SLOT_W-1:0] wr_slot;
   logic [LEN_W-1:0]  bw_cur;
   logic              over;
   logic [LEN_W-1:0]  bw_new;
   logic              tl_new;
   logic              wr_ok;
   logic              wr_done;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              load_any;

   assign limit   = (limit_ff > LEN_W'(SLOT_BYTES)) ? LEN_W'(SLOT_BYTES) : limit_ff;
   assign start   = !open_ff;
   assign flush   = start && ready_ff[wp_ff] && (&ready_ff);
   assign wr_slot = start ? (flush ? '0 : wp_ff) : cws_ff;
   assign bw_cur  = start ? '0 : bw_ff;
   assign over    = (bw_cur >= limit);
   assign bw_new  = over ? bw_cur : bw_cur + 1'b1;
   assign tl_new  = (!start && too_long_ff) || over;
   assign wr_ok   = !tl_new && (bw_new != '0);
   assign wr_done = cmd.write && req_last_byte;
   assign wr_addr = ADDR_W'(wr_slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(bw_cur);
   assign rd_addr = ADDR_W'(rp_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(fetch_idx_ff);

   always_comb begin
      ready_in     = ready_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      cws_in       = cws_ff;
      bw_in        = bw_ff;
      open_in      = open_ff;
      too_long_in  = too_long_ff;
      fetch_idx_in = fetch_idx_ff;
      pending_in   = pending_ff;

      if (cmd.write) begin
         if (flush) begin
            ready_in = '0;
            rp_in    = '0;
            wp_in    = SLOT_W'(1);
         end
         if (start) begin
            ready_in[wr_slot] = 1'b0;
         end
         cws_in      = wr_slot;
         bw_in       = bw_new;
         too_long_in = tl_new;
         open_in     = !req_last_byte;
         if (wr_done && wr_ok) begin
            ready_in[wr_slot] = 1'b1;
            wp_in             = next_slot(wr_slot);
         end
      end

      if (cmd.read_start) begin
         fetch_idx_in = '0;
         pending_in   = 1'b0;
      end
      if (cmd.fetch) begin
         fetch_idx_in = fetch_idx_ff + 1'b1;
         pending_in   = 1'b1;
      end else if (cmd.load) begin
         pending_in = 1'b0;
      end
      if (cmd.finish) begin
         ready_in[rp_ff] = 1'b0;
         rp_in           = next_slot(rp_ff);
      end
   end

   assign load_any = wr_done || cmd.emit_empty || cmd.load;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_any) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= psrb_pkg::LIMIT_RESET;
         ready_ff     <= '0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         cws_ff       <= '0;
         bw_ff        <= '0;
         open_ff      <= 1'b0;
         too_long_ff  <= 1'b0;
         fetch_idx_ff <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         ready_ff     <= ready_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         cws_ff       <= cws_in;
         bw_ff        <= bw_in;
         open_ff      <= open_in;
         too_long_ff  <= too_long_in;
         fetch_idx_ff <= fetch_idx_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Packet store and slot length table.
   always_ff @(posedge clock) begin
      if (cmd.write && !over) begin
         store_mem[wr_addr] <= req_data_byte;
      end
      if (cmd.fetch) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_done && wr_ok) begin
         len_mem[wr_slot] <= bw_new;
      end
      if (cmd.read_start) begin
         rd_len_ff <= len_mem[rp_ff];
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (wr_done) begin
         kind_ff <= psrb_pkg::KIND_WRITE_STATUS;
         byte_ff <= '0;
         last_ff <= 1'b1;
         ok_ff   <= wr_ok;
         len_ff  <= wr_ok ? bw_new : '0;
      end else if (cmd.emit_empty) begin
         kind_ff <= psrb_pkg::KIND_READ_EMPTY;
         byte_ff <= '0;
         last_ff <= 1'b1;
         ok_ff   <= 1'b0;
         len_ff  <= '0;
      end else if (cmd.load) begin
         kind_ff <= psrb_pkg::KIND_READ_DATA;
         byte_ff <= rd_data_ff;
         last_ff <= (fetch_idx_ff == rd_len_ff);
         ok_ff   <= 1'b0;
         len_ff  <= rd_len_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.rd_hit   = ready_ff[rp_ff] && (rd_len_ff != '0);
   assign status.more     = (fetch_idx_ff < rd_len_ff);
   assign status.pending  = pending_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_out_last      = last_ff;
   assign rsp_write_ok      = ok_ff;
   assign rsp_packet_length = len_ff;

endmodule

[src/packet_slot_ring_buffer.sv]
// Packet ring buffer with SLOTS fixed slots of SLOT_BYTES bytes each. A write request carries
// one packet byte; the byte flagged last closes the packet and produces one write status
// response (stored with its length, or rejected with length 0 when the packet exceeded the
// length limit, which is the smaller of the configured limit and SLOT_BYTES). Write requests
// are taken one per cycle as long as the output register can take a response; any request,
// write or read, is held off while a response waits in a stalled output register. A packet
// that starts while every slot holds a ready packet flushes the whole buffer and lands in
// slot 0. A read request streams the oldest ready packet as one response per byte, the final
// one flagged last, or returns a single empty response. A read takes the request and looks
// up the slot length, then checks the slot, then performs the registered packet store read,
// then delivers one byte per cycle while the response side does not stall; an empty read
// ends after the check, once the output register can take its response. No further
// requests are taken while a read is streaming. The length limit may be written at any time
// the block is idle.
module packet_slot_ring_buffer #(
   parameter int SLOTS      = psrb_pkg::SLOTS_DEFAULT,
   parameter int SLOT_BYTES = psrb_pkg::SLOT_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,

   // Configuration: packet length limit.
   input  logic                         csr_wr_en,
   input  logic [psrb_pkg::LEN_W-1:0]   csr_wr_data,

   // Request channel.
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [psrb_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                         req_last_byte,

   // Response channel.
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [psrb_pkg::KIND_W-1:0]  rsp_result_kind,
   output logic [psrb_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_out_last,
   output logic                         rsp_write_ok,
   output logic [psrb_pkg::LEN_W-1:0]   rsp_packet_length
);

   // The controller sequences requests and read streams; the datapath owns the
   // pointers, slot ready bits, memories and the output register.
   psrb_pkg::ctrl_cmd_type    cmd;
   psrb_pkg::ctrl_status_type status;

   psrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   psrb_datapath #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_last      (rsp_out_last),
      .rsp_write_ok      (rsp_write_ok),
      .rsp_packet_length (rsp_packet_length)
   );

endmodule

[tb/psrb_checker.sv]
`timescale 1ns / 1ps

module psrb_checker #(
   parameter int SLOTS      = psrb_pkg::SLOTS_DEFAULT,
   parameter int SLOT_BYTES = psrb_pkg::SLOT_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [psrb_pkg::LEN_W-1:0]   csr_wr_data,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [psrb_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                         req_last_byte,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [psrb_pkg::KIND_W-1:0]  rsp_result_kind,
   input  logic [psrb_pkg::BYTE_W-1:0]  rsp_out_byte,
   input  logic                         rsp_out_last,
   input  logic                         rsp_write_ok,
   input  logic [psrb_pkg::LEN_W-1:0]   rsp_packet_length,
   output int                           fail_count,
   output int                           pending_results
);

   typedef struct packed {
      logic [psrb_pkg::KIND_W-1:0] kind;
      logic [psrb_pkg::BYTE_W-1:0] value;
      logic                        last;
      logic                        ok;
      logic [psrb_pkg::LEN_W-1:0]  length;
   } ring_rsp_type;

   ring_rsp_type                responses_due[$];
   logic [SLOTS-1:0]            slot_full;
   logic [psrb_pkg::LEN_W-1:0]  slot_len [SLOTS];
   logic [psrb_pkg::BYTE_W-1:0] slot_bytes [SLOTS*SLOT_BYTES];
   int                          oldest_slot;
   int                          next_slot_free;
   int                          fill_slot;
   int                          fill_count;
   bit                          filling;
   bit                          overflowed;
   logic [psrb_pkg::LEN_W-1:0]  len_limit;

   function automatic void expect_rsp(logic [psrb_pkg::KIND_W-1:0] kind,
                                      logic [psrb_pkg::BYTE_W-1:0] value,
                                      logic last, logic ok,
                                      logic [psrb_pkg::LEN_W-1:0] length);
      ring_rsp_type r;
      r.kind   = kind;
      r.value  = value;
      r.last   = last;
      r.ok     = ok;
      r.length = length;
      responses_due.push_back(r);
   endfunction

   function automatic void clear_ring();
      slot_full = '0;
      foreach (slot_len[i]) slot_len[i] = '0;
      oldest_slot    = 0;
      next_slot_free = 0;
      fill_slot      = 0;
      fill_count     = 0;
      filling        = 1'b0;
      overflowed     = 1'b0;
   endfunction

   // Updates the ring copy for one accepted request and queues its responses.
   function automatic void apply_request(logic cmd, logic [psrb_pkg::BYTE_W-1:0] value,
                                         logic last);
      int cap;
      int n;
      logic [psrb_pkg::LEN_W-1:0] n_len;
      cap = (int'(len_limit) > SLOT_BYTES) ? SLOT_BYTES : int'(len_limit);
      if (cmd == psrb_pkg::CMD_WRITE) begin
         if (!filling) begin
            // A packet that starts on a completely full ring flushes it.
            if (&slot_full) begin
               slot_full = '0;
               foreach (slot_len[i]) slot_len[i] = '0;
               oldest_slot    = 0;
               fill_slot      = 0;
               next_slot_free = 1;
            end else begin
               fill_slot = next_slot_free;
            end
            slot_full[fill_slot] = 1'b0;
            filling    = 1'b1;
            fill_count = 0;
            overflowed = 1'b0;
         end
         if (fill_count >= cap) begin
            overflowed = 1'b1;
         end else begin
            slot_bytes[fill_slot*SLOT_BYTES + fill_count] = value;
            fill_count++;
         end
         if (last) begin
            filling = 1'b0;
            n_len   = fill_count[psrb_pkg::LEN_W-1:0];
            if (overflowed || fill_count == 0) begin
               expect_rsp(psrb_pkg::KIND_WRITE_STATUS, '0, 1'b1, 1'b0, '0);
            end else begin
               slot_full[fill_slot] = 1'b1;
               slot_len[fill_slot]  = n_len;
               next_slot_free       = (fill_slot + 1) % SLOTS;
               expect_rsp(psrb_pkg::KIND_WRITE_STATUS, '0, 1'b1, 1'b1, n_len);
            end
         end
      end else begin
         n     = int'(slot_len[oldest_slot]);
         n_len = slot_len[oldest_slot];
         if (!slot_full[oldest_slot] || n == 0) begin
            expect_rsp(psrb_pkg::KIND_READ_EMPTY, '0, 1'b1, 1'b0, '0);
         end else begin
            for (int k = 0; k < n; k++)
               expect_rsp(psrb_pkg::KIND_READ_DATA, slot_bytes[oldest_slot*SLOT_BYTES + k],
                          k == n - 1, 1'b0, n_len);
            slot_full[oldest_slot] = 1'b0;
            oldest_slot = (oldest_slot + 1) % SLOTS;
         end
      end
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   function automatic void compare_response();
      ring_rsp_type want;
      if (responses_due.size() == 0) begin
         fail_count++;
         $display("%0t: response with none expected, actual kind %0d byte %0d last %0d",
                  $time, rsp_result_kind, rsp_out_byte, rsp_out_last);
         $display("%0t: ... ok %0d len %0d", $time, rsp_write_ok, rsp_packet_length);
      end else begin
         want = responses_due.pop_front();
         check_field("result_kind", int'(want.kind), int'(rsp_result_kind));
         check_field("out_byte", int'(want.value), int'(rsp_out_byte));
         check_field("out_last", int'(want.last), int'(rsp_out_last));
         check_field("write_ok", int'(want.ok), int'(rsp_write_ok));
         check_field("packet_length", int'(want.length), int'(rsp_packet_length));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_ring();
         responses_due.delete();
         fail_count = 0;
         len_limit  = psrb_pkg::LIMIT_RESET;
      end else begin
         if (csr_wr_en)
            len_limit = csr_wr_data;
         if (rsp_valid && !rsp_stall)
            compare_response();
         if (req_valid && !req_stall)
            apply_request(req_cmd, req_data_byte, req_last_byte);
      end
      pending_results <= responses_due.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

   // Cycles to let pass after the last response before a register write, and at the end,
   // which must cover a full-length read in case the block sends something unexpected.
   localparam int SETTLE_CYCLES = 6;
   localparam int END_CYCLES    = 80;
   // Generous ceiling on the whole run; a correct run needs a few percent of it.
   localparam int unsigned RUN_LIMIT = 300000;

   logic                        clock         = 1'b0;
   logic                        reset         = 1'b1;
   logic                        csr_wr_en     = 1'b0;
   logic [psrb_pkg::LEN_W-1:0]  csr_wr_data   = '0;
   logic                        req_valid     = 1'b0;
   logic                        req_stall;
   logic                        req_cmd       = psrb_pkg::CMD_WRITE;
   logic [psrb_pkg::BYTE_W-1:0] req_data_byte = '0;
   logic                        req_last_byte = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall     = 1'b0;
   logic [psrb_pkg::KIND_W-1:0] rsp_result_kind;
   logic [psrb_pkg::BYTE_W-1:0] rsp_out_byte;
   logic                        rsp_out_last;
   logic                        rsp_write_ok;
   logic [psrb_pkg::LEN_W-1:0]  rsp_packet_length;

   int                fail_count;
   int                pending_results;

   // Stimulus bookkeeping: idle rates of both sides in percent, the number of requests
   // accepted so far, whether a packet is left open, and the limit last written.
   int                send_idle_pct;
   int                rcv_idle_pct;
   int                requests_sent = 0;
   bit                mid_packet    = 1'b0;
   int                limit_now     = 64;
   int unsigned       cycle_count   = 0;

   always #10 clock = ~clock;

   packet_slot_ring_buffer dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_last      (rsp_out_last),
      .rsp_write_ok      (rsp_write_ok),
      .rsp_packet_length (rsp_packet_length)
   );

   // The checker watches both channels and the register port, keeps its own copy of the
   // ring, and reports how many mismatches it saw and how many responses are still due.
   psrb_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_last      (rsp_out_last),
      .rsp_write_ok      (rsp_write_ok),
      .rsp_packet_length (rsp_packet_length),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   // The receiver stalls at random at the rate of the current phase.
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   // A run that hangs, for example because a response never arrives, ends here.
   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // Offers one request and returns at the clock edge that accepts it. A random gap
   // before the request lets the sender idle; without a gap valid stays high, so
   // back-to-back requests follow each other without a bubble.
   task automatic send_request(input logic cmd, input logic [psrb_pkg::BYTE_W-1:0] value,
                               input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= value;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == psrb_pkg::CMD_WRITE)
         mid_packet = !last;
      requests_sent++;
   endtask

   // Read requests carry random data and last bits, which the block must ignore.
   task automatic send_read();
      send_request(psrb_pkg::CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   task automatic send_packet(input int len);
      for (int i = 0; i < len; i++)
         send_request(psrb_pkg::CMD_WRITE, 8'($urandom_range(255)), i == len - 1);
   endtask

   // Stops offering requests and waits until every expected response has arrived,
   // then lets the block settle before returning.
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // The limit register is only written while the block is idle.
   task automatic set_limit(input logic [psrb_pkg::LEN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      limit_now = int'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random phase. Most requests form whole packets with random content, mostly
   // short, some of up to twelve bytes, and some right at the limit or one byte past it.
   // Reads are somewhat less frequent than packets so the ring fills up and flushes.
   // The rest is noise: single requests of any kind, which leave packets open across
   // reads or close them early.
   task automatic run_phase(input int count);
      int start;
      int eff;
      int pick;
      int len;
      start = requests_sent;
      eff   = (limit_now > psrb_pkg::SLOT_BYTES_DEFAULT) ? psrb_pkg::SLOT_BYTES_DEFAULT
                                                         : limit_now;
      while (requests_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            pick = $urandom_range(99);
            if (pick < 80)
               len = $urandom_range(1, 6);
            else if (pick < 92 && eff <= 8)
               len = eff + int'($urandom_range(1));
            else if (pick < 97)
               len = $urandom_range(1, 12);
            else
               len = eff + int'($urandom_range(1));
            if (len == 0)
               len = 1;
            send_packet(len);
         end else if (pick < 85) begin
            send_read();
         end else begin
            send_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                         $urandom_range(3) == 0);
         end
      end
      // Leave no packet open across a register write.
      if (mid_packet)
         send_request(psrb_pkg::CMD_WRITE, 8'($urandom_range(255)), 1'b1);
   endtask

   initial begin
      send_idle_pct = 10;
      rcv_idle_pct  = 76;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with a limit of two bytes.
      set_limit(7'd2);
      // A read on an empty ring.
      send_read();
      // A one-byte packet of all zeros and a two-byte packet at the limit.
      send_request(psrb_pkg::CMD_WRITE, 8'h00, 1'b1);
      send_request(psrb_pkg::CMD_WRITE, 8'hFF, 1'b0);
      send_request(psrb_pkg::CMD_WRITE, 8'hA5, 1'b1);
      send_read();
      send_read();
      // A packet one byte over the limit is rejected and leaves its slot free.
      send_request(psrb_pkg::CMD_WRITE, 8'h11, 1'b0);
      send_request(psrb_pkg::CMD_WRITE, 8'h22, 1'b0);
      send_request(psrb_pkg::CMD_WRITE, 8'h33, 1'b1);
      send_read();
      // A read arrives while a packet is half written; the open slot is not ready.
      send_request(psrb_pkg::CMD_WRITE, 8'h44, 1'b0);
      send_read();
      send_request(psrb_pkg::CMD_WRITE, 8'h55, 1'b1);
      drain(SETTLE_CYCLES);

      // With a zero limit every packet is rejected.
      set_limit(7'd0);
      send_request(psrb_pkg::CMD_WRITE, 8'h66, 1'b1);
      drain(SETTLE_CYCLES);

      // Seven one-byte packets fill the ring; the eighth flushes it and lands in slot 0,
      // so one read returns it and the next finds the ring empty.
      set_limit(7'd1);
      for (int i = 0; i < 8; i++)
         send_request(psrb_pkg::CMD_WRITE, 8'(8'h80 + i), 1'b1);
      send_read();
      send_read();
      drain(SETTLE_CYCLES);

      // Random phases. Each ends by pausing the sender until every response is back,
      // which also makes the ring idle for the next register write. The first runs
      // with a limit above the slot size, which the block clamps.
      set_limit(7'd127);
      run_phase(45);
      drain(SETTLE_CYCLES);

      send_idle_pct = 76;
      rcv_idle_pct  = 10;
      set_limit(7'd5);
      run_phase(45);
      drain(SETTLE_CYCLES);

      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      set_limit(7'd64);
      run_phase(45);
      drain(END_CYCLES);

      if (fail_count == 0 && pending_results == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
